[hdl/matrix_arith_unit_defines.svh]
// assertion macros used by the checker file
`ifndef MATRIX_ARITH_UNIT_DEFINES_SVH
`define MATRIX_ARITH_UNIT_DEFINES_SVH

// same-cycle implication, sampled on the rising clock, off during reset
`define MAU_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on the rising clock, off during reset
`define MAU_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hdl/mau_pkg.sv]
`default_nettype none
package mau_pkg;

	// fixed field widths
	localparam int IDX_W  = 3;
	localparam int DIM_W  = 4;
	localparam int DATA_W = 32;
	localparam int CFG_IDX_W = 2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ROWS_A = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COLS_A = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COLS_B = 2'd2;

	// operation codes
	typedef enum logic [2:0] {
		OP_LOAD_A    = 3'd0,
		OP_LOAD_B    = 3'd1,
		OP_ADD       = 3'd2,
		OP_SUB       = 3'd3,
		OP_MUL       = 3'd4,
		OP_TRANSPOSE = 3'd5
	} op_t;

	// control that travels with each store read
	typedef struct packed {
		logic             valid;
		op_t              op;
		logic [IDX_W-1:0] row;
		logic [IDX_W-1:0] col;
		logic             first;
		logic             last_inner;
		logic             last_elem;
	} mau_ctl_t;

	// zero counts as one, anything above the limit as the limit
	function automatic logic [DIM_W-1:0] sat_dim(input logic [DIM_W-1:0] v,
			input logic [DIM_W-1:0] lim);
		logic [DIM_W-1:0] r;
		if (v == '0) begin
			r = {{(DIM_W-1){1'b0}}, 1'b1};
		end else if (v > lim) begin
			r = lim;
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage
`default_nettype wire

[hdl/matrix_arith_unit.sv]
`default_nettype none
// Matrix engine with two element stores, A and B, each a one-port-read RAM.
// A load (op 0 or 1) writes one element in the cycle it is taken and never
// raises busy, so loads go in one per cycle while busy is low. A command
// (add, subtract, multiply, transpose) raises busy and walks the stores one
// read per cycle: add, subtract and transpose read once per result element,
// multiply reads cols_a times per element since the dot product reuses a single
// multiplier and one read port per store. Each read passes the store's read
// register, the operation register and the result register before its
// result shows, and busy drops together with the final result. Results come out
// in row-major order, each for one cycle under strobe, and cannot be
// stalled; last marks the final element, and busy is already low in that
// cycle. Unused codes 6 and 7 are taken and do nothing. The stores have no
// reset; read only entries that were loaded.
module matrix_arith_unit
	import mau_pkg::*;
#(
	parameter int MAX_DIM = 8
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [DIM_W-1:0]     cfg_data,
	input  wire logic                 start,
	output logic                      busy,
	input  wire logic [2:0]           operation,
	input  wire logic [IDX_W-1:0]     row,
	input  wire logic [IDX_W-1:0]     col,
	input  wire logic signed [DATA_W-1:0] value,
	output logic                      strobe,
	output logic [IDX_W-1:0]          row_res,
	output logic [IDX_W-1:0]          col_res,
	output logic signed [DATA_W-1:0]  value_res,
	output logic                      last
);

	localparam int DEPTH  = MAX_DIM * MAX_DIM;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [DIM_W-1:0] DIM_LIM = DIM_W'(MAX_DIM);

	logic [DIM_W-1:0]  rows_a_q, cols_a_q, cols_b_q;
	op_t               op_in;
	logic              accept, in_range, load_a, load_b, cmd_go;
	logic [ADDR_W-1:0] waddr, addr_a, addr_b;
	logic [DATA_W-1:0] rd_a, rd_b;
	mau_ctl_t          ctl, ctl_s1, ctl_s2;
	logic [DATA_W-1:0] value_s2, acc_q, acc_next;
	logic              fin;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_a_q <= DIM_W'(8);
			cols_a_q <= DIM_W'(8);
			cols_b_q <= DIM_W'(8);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ROWS_A: rows_a_q <= cfg_data;
				REG_COLS_A: cols_a_q <= cfg_data;
				REG_COLS_B: cols_b_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// input beat decode
	assign op_in    = op_t'(operation);
	assign accept   = start && !busy;
	assign in_range = (32'(row) < MAX_DIM) && (32'(col) < MAX_DIM);
	assign load_a   = accept && (op_in == OP_LOAD_A) && in_range;
	assign load_b   = accept && (op_in == OP_LOAD_B) && in_range;
	assign cmd_go   = accept && ((op_in == OP_ADD) || (op_in == OP_SUB) ||
		(op_in == OP_MUL) || (op_in == OP_TRANSPOSE));
	assign waddr    = ADDR_W'(32'(row) * MAX_DIM + 32'(col));

	mau_seq #(
		.MAX_DIM (MAX_DIM)
	) u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (cmd_go),
		.op     (op_in),
		.rows_a (sat_dim(rows_a_q, DIM_LIM)),
		.cols_a (sat_dim(cols_a_q, DIM_LIM)),
		.cols_b (sat_dim(cols_b_q, DIM_LIM)),
		.fin    (fin),
		.busy   (busy),
		.ctl    (ctl),
		.addr_a (addr_a),
		.addr_b (addr_b)
	);

	mau_ram #(
		.WIDTH (DATA_W),
		.DEPTH (DEPTH)
	) u_store_a (
		.clk   (clk),
		.we    (load_a),
		.waddr (waddr),
		.wdata (value),
		.re    (ctl.valid),
		.raddr (addr_a),
		.rdata (rd_a)
	);

	mau_ram #(
		.WIDTH (DATA_W),
		.DEPTH (DEPTH)
	) u_store_b (
		.clk   (clk),
		.we    (load_b),
		.waddr (waddr),
		.wdata (value),
		.re    (ctl.valid),
		.raddr (addr_b),
		.rdata (rd_b)
	);

	// control follows the read data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
		end else begin
			ctl_s1 <= ctl;
			ctl_s2 <= ctl_s1;
		end
	end

	// element operation or product term
	always_ff @(posedge clk) begin
		unique case (ctl_s1.op)
			OP_MUL:  value_s2 <= rd_a * rd_b;
			OP_ADD:  value_s2 <= rd_a + rd_b;
			OP_SUB:  value_s2 <= rd_a - rd_b;
			default: value_s2 <= rd_a;
		endcase
	end

	// dot product accumulation, single term for elementwise ops
	assign acc_next = (ctl_s2.first ? '0 : acc_q) + value_s2;
	assign fin      = ctl_s2.valid && ctl_s2.last_elem;

	always_ff @(posedge clk) begin
		if (ctl_s2.valid) begin
			acc_q <= acc_next;
		end
		if (ctl_s2.valid && ctl_s2.last_inner) begin
			row_res   <= ctl_s2.row;
			col_res   <= ctl_s2.col;
			value_res <= acc_next;
		end
	end

	// result strobe and end mark
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe <= 1'b0;
			last   <= 1'b0;
		end else begin
			strobe <= ctl_s2.valid && ctl_s2.last_inner;
			last   <= fin;
		end
	end

endmodule
`default_nettype wire

[hdl/mau_ram.sv]
`default_nettype none
module mau_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                                      clk,
	input  wire logic                                      we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                          wdata,
	input  wire logic                                      re,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

[hdl/mau_seq.sv]
`default_nettype none
module mau_seq
	import mau_pkg::*;
#(
	parameter int MAX_DIM = 8
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 go,
	input  wire op_t                  op,
	input  wire logic [DIM_W-1:0]     rows_a,
	input  wire logic [DIM_W-1:0]     cols_a,
	input  wire logic [DIM_W-1:0]     cols_b,
	input  wire logic                 fin,
	output logic                      busy,
	output mau_ctl_t                  ctl,
	output logic [((MAX_DIM*MAX_DIM > 1) ? $clog2(MAX_DIM*MAX_DIM) : 1)-1:0] addr_a,
	output logic [((MAX_DIM*MAX_DIM > 1) ? $clog2(MAX_DIM*MAX_DIM) : 1)-1:0] addr_b
);

	localparam int ADDR_W = (MAX_DIM*MAX_DIM > 1) ? $clog2(MAX_DIM*MAX_DIM) : 1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ISSUE,
		ST_DRAIN
	} state_t;

	state_t           state_q;
	logic             busy_q;
	op_t              op_q;
	logic [IDX_W-1:0] r_q, c_q, i_q;
	logic [DIM_W-1:0] nr_q, nc_q, ni_q;
	logic             r_last, c_last, i_last;
	logic [IDX_W-1:0] ar_row, ar_col, br_row, br_col;

	// loop ends
	assign r_last = ({1'b0, r_q} + 1'b1) == nr_q;
	assign c_last = ({1'b0, c_q} + 1'b1) == nc_q;
	assign i_last = ({1'b0, i_q} + 1'b1) == ni_q;

	// store coordinates per operation
	always_comb begin
		ar_row = r_q;
		ar_col = c_q;
		br_row = r_q;
		br_col = c_q;
		unique case (op_q)
			OP_MUL: begin
				ar_col = i_q;
				br_row = i_q;
			end
			OP_TRANSPOSE: begin
				ar_row = c_q;
				ar_col = r_q;
			end
			default: begin
			end
		endcase
	end

	assign addr_a = ADDR_W'(32'(ar_row) * MAX_DIM + 32'(ar_col));
	assign addr_b = ADDR_W'(32'(br_row) * MAX_DIM + 32'(br_col));

	// read beat control
	always_comb begin
		ctl.valid      = (state_q == ST_ISSUE);
		ctl.op         = op_q;
		ctl.row        = r_q;
		ctl.col        = c_q;
		ctl.first      = (i_q == '0);
		ctl.last_inner = i_last;
		ctl.last_elem  = r_last && c_last && i_last;
	end

	assign busy = busy_q;

	// walk state, loop counters and bounds
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			busy_q  <= 1'b0;
			op_q    <= OP_ADD;
			r_q     <= '0;
			c_q     <= '0;
			i_q     <= '0;
			nr_q    <= '0;
			nc_q    <= '0;
			ni_q    <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (go) begin
						state_q <= ST_ISSUE;
						busy_q  <= 1'b1;
						op_q    <= op;
						r_q     <= '0;
						c_q     <= '0;
						i_q     <= '0;
						nr_q    <= (op == OP_TRANSPOSE) ? cols_a : rows_a;
						nc_q    <= (op == OP_TRANSPOSE) ? rows_a :
							(op == OP_MUL) ? cols_b : cols_a;
						ni_q    <= (op == OP_MUL) ? cols_a : DIM_W'(1);
					end
				end
				ST_ISSUE: begin
					if (!i_last) begin
						i_q <= i_q + 1'b1;
					end else begin
						i_q <= '0;
						if (!c_last) begin
							c_q <= c_q + 1'b1;
						end else begin
							c_q <= '0;
							if (r_last) begin
								state_q <= ST_DRAIN;
							end else begin
								r_q <= r_q + 1'b1;
							end
						end
					end
				end
				ST_DRAIN: begin
					if (fin) begin
						state_q <= ST_IDLE;
						busy_q  <= 1'b0;
					end
				end
				default: begin
					state_q <= ST_IDLE;
					busy_q  <= 1'b0;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

[hdl/mau_checker.sv]
`default_nettype none
`include "matrix_arith_unit_defines.svh"
module mau_checker
	import mau_pkg::*;
(
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       start,
	input wire logic       busy,
	input wire logic [2:0] operation,
	input wire logic       strobe,
	input wire logic       last
);

	logic is_load, is_cmd;

	assign is_load = (operation == OP_LOAD_A) || (operation == OP_LOAD_B);
	assign is_cmd  = (operation == OP_ADD) || (operation == OP_SUB) ||
		(operation == OP_MUL) || (operation == OP_TRANSPOSE);

	// a taken command holds the block, with no result in its first cycle
	`MAU_ASSERT_NEXT(a_cmd_busy, start && !busy && is_cmd, busy && !strobe, "command did not raise busy")
	// loads never block the next beat
	`MAU_ASSERT_NEXT(a_load_free, start && !busy && is_load, !busy, "load raised busy")
	// results other than the final one only while busy
	`MAU_ASSERT_NOW(a_mid_busy, strobe && !last, busy, "result outside a command")
	// busy is released by the time the final result shows
	`MAU_ASSERT_NOW(a_last_free, strobe && last, !busy, "busy held after final result")
	// end mark only on a result beat
	`MAU_ASSERT_NOW(a_last_strobe, last, strobe, "last without strobe")

endmodule

bind matrix_arith_unit mau_checker u_mau_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.operation (operation),
	.strobe    (strobe),
	.last      (last)
);
`default_nettype wire
